// ----- rtl/phdc_pkg.sv -----
// Package for the pH dosing controller.
// Holds word types, phase codes, register indexes and reset values; no dependencies.
package phdc_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [15:0] CHECK_INTERVAL_RST = 16'd30000;
    localparam logic [15:0] WAIT_INTERVAL_RST  = 16'd18000;
    localparam logic [15:0] MIX_MS_RST         = 16'd1000;
    localparam logic [7:0]  LOWER_LIMIT_RST    = 8'd55;
    localparam logic [7:0]  UPPER_LIMIT_RST    = 8'd65;
    localparam logic [7:0]  TARGET_RST         = 8'd60;

    localparam logic [10:0] ADC_FULL_SCALE = 11'd1023;
    localparam logic [13:0] PH_SCALE       = 14'd14;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_DOSING  = 2'd1,
        PH_MIXING  = 2'd2,
        PH_WAITING = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        REG_CHECK_INTERVAL = 3'd0,
        REG_WAIT_INTERVAL  = 3'd1,
        REG_MIX_MS         = 3'd2,
        REG_LOWER_LIMIT    = 3'd3,
        REG_UPPER_LIMIT    = 3'd4,
        REG_TARGET         = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [9:0]  adc_sample;
        logic [15:0] dose_ms;
    } in_word_t;

    typedef struct packed {
        logic       acid_pump_on;
        logic       base_pump_on;
        logic       mix_pump_on;
        logic [1:0] phase_now;
        logic       checked;
        logic [3:0] ph_units;
    } out_word_t;

    typedef struct packed {
        logic [15:0] check_interval_ms;
        logic [15:0] wait_interval_ms;
        logic [15:0] mix_ms;
        logic [7:0]  lower_limit_tenths;
        logic [7:0]  upper_limit_tenths;
        logic [7:0]  target_tenths;
    } cfg_t;

    // classified tick as queued between front and back
    typedef struct packed {
        logic        out_of_range;
        logic        acid;
        logic [3:0]  ph_units;
        logic [15:0] dose_ms;
    } cls_t;

endpackage

// ----- rtl/phdc_front.sv -----
// Front end: maps the ADC sample to pH units and classifies it against the limits.
// Depends on phdc_pkg.
module phdc_front
    import phdc_pkg::*;
(
    input  in_word_t in_word,
    input  cfg_t     cfg,
    output cls_t     cls
);

    logic [13:0] scaled;
    logic [3:0]  q0;
    logic [10:0] rem_adj;
    logic [3:0]  units;
    logic [7:0]  tenths;

    always_comb
    begin
        scaled  = 14'(in_word.adc_sample) * PH_SCALE;
        // x/1023 = x/1024 plus one correction step
        q0      = scaled[13:10];
        rem_adj = {1'b0, scaled[9:0]} + 11'(q0);
        units   = q0 + 4'(rem_adj >= ADC_FULL_SCALE);
        tenths  = {1'b0, units, 3'b000} + {3'b000, units, 1'b0};

        cls.out_of_range = (tenths < cfg.lower_limit_tenths) ||
                           (tenths > cfg.upper_limit_tenths);
        cls.acid         = !(tenths < cfg.target_tenths);
        cls.ph_units     = units;
        cls.dose_ms      = in_word.dose_ms;
    end

endmodule

// ----- rtl/phdc_queue.sv -----
// Short FIFO between front and back ends.
// Depends on phdc_pkg.
module phdc_queue
    import phdc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cls_t push_word,
    output logic full,
    input  logic pop,
    output cls_t pop_word,
    output logic not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cls_t          store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        wrap_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_word  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ----- rtl/phdc_back.sv -----
// Back end: phase sequencer, elapsed-time counter and registered output word.
// Depends on phdc_pkg.
module phdc_back
    import phdc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_valid,
    input  cls_t      q_word,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    phase_t      phase_reg, phase_next;
    logic [15:0] since_reg, since_next;
    logic [15:0] mix_left_reg, mix_left_next;
    logic        acid_reg, acid_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_data_reg, out_data_next;

    phase_t      ph1;
    logic        chk;
    logic [15:0] elapsed;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        q_pop          = q_valid && (!out_valid_reg || out_ready);
        phase_next     = phase_reg;
        since_next     = since_reg;
        mix_left_next  = mix_left_reg;
        acid_next      = acid_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        ph1            = phase_reg;
        chk            = ((phase_reg == PH_IDLE) && (since_reg >= cfg.check_interval_ms)) ||
                         ((phase_reg == PH_WAITING) && (since_reg >= cfg.wait_interval_ms));
        elapsed        = chk ? '0 : since_reg;

        if (q_pop)
        begin
            if (chk)
            begin
                ph1 = q_word.out_of_range ? PH_DOSING : PH_IDLE;
                if (q_word.out_of_range)
                begin
                    acid_next = q_word.acid;
                end
            end
            phase_next = ph1;

            if ((ph1 == PH_DOSING) && (elapsed >= q_word.dose_ms))
            begin
                if (cfg.mix_ms == '0)
                begin
                    phase_next = PH_WAITING;
                end
                else
                begin
                    phase_next    = PH_MIXING;
                    mix_left_next = cfg.mix_ms - 16'd1;
                end
            end
            else if (phase_reg == PH_MIXING)
            begin
                if (mix_left_reg == '0)
                begin
                    phase_next = PH_WAITING;
                end
                else
                begin
                    mix_left_next = mix_left_reg - 16'd1;
                end
            end

            if (elapsed != 16'hFFFF)
            begin
                since_next = elapsed + 16'd1;
            end
            else
            begin
                since_next = elapsed;
            end

            out_valid_next              = 1'b1;
            out_data_next.acid_pump_on  = (phase_next == PH_DOSING) && acid_next;
            out_data_next.base_pump_on  = (phase_next == PH_DOSING) && !acid_next;
            out_data_next.mix_pump_on   = (phase_next == PH_MIXING);
            out_data_next.phase_now     = phase_next;
            out_data_next.checked       = chk;
            out_data_next.ph_units      = q_word.ph_units;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            since_reg     <= '0;
            mix_left_reg  <= '0;
            acid_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            since_reg     <= since_next;
            mix_left_reg  <= mix_left_next;
            acid_reg      <= acid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// ----- rtl/ph_dosing_controller.sv -----
// An accepted input word is written into the queue, then its result word is registered at the back end output.
// Throughput: one word per cycle while out_ready takes results; set by the back end's phase update.
// The 2-entry queue keeps input flowing while an output word waits to be taken.
// Reset (rst_n, async, active low): phase idle, counters zero, registers to defaults.
// Top level of the pH dosing controller; uses phdc_pkg, phdc_front, phdc_queue, phdc_back.
module ph_dosing_controller
    import phdc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    cls_t cls;
    cls_t q_word;
    logic q_full;
    logic q_valid;
    logic q_pop;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_CHECK_INTERVAL: cfg_next.check_interval_ms  = cfg_data;
                REG_WAIT_INTERVAL:  cfg_next.wait_interval_ms   = cfg_data;
                REG_MIX_MS:         cfg_next.mix_ms             = cfg_data;
                REG_LOWER_LIMIT:    cfg_next.lower_limit_tenths = cfg_data[7:0];
                REG_UPPER_LIMIT:    cfg_next.upper_limit_tenths = cfg_data[7:0];
                REG_TARGET:         cfg_next.target_tenths      = cfg_data[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_interval_ms  <= CHECK_INTERVAL_RST;
            cfg_reg.wait_interval_ms   <= WAIT_INTERVAL_RST;
            cfg_reg.mix_ms             <= MIX_MS_RST;
            cfg_reg.lower_limit_tenths <= LOWER_LIMIT_RST;
            cfg_reg.upper_limit_tenths <= UPPER_LIMIT_RST;
            cfg_reg.target_tenths      <= TARGET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    phdc_front u_front (
        .in_word (in_data),
        .cfg     (cfg_reg),
        .cls     (cls)
    );

    phdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_word (cls),
        .full      (q_full),
        .pop       (q_pop),
        .pop_word  (q_word),
        .not_empty (q_valid)
    );

    phdc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_word    (q_word),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- rtl/phdc_checker.sv -----
// Port-level checks on the pH dosing controller's output words, and the bind.
// Depends on phdc_pkg and ph_dosing_controller.
module phdc_checker
    import phdc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    a_one_pump: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.acid_pump_on && out_data.base_pump_on))
        else $error("acid and base pumps both on");

    a_dose_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.acid_pump_on || out_data.base_pump_on)
        |-> out_data.phase_now == PH_DOSING)
        else $error("dose pump on outside dosing");

    a_mix_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.mix_pump_on == (out_data.phase_now == PH_MIXING))
        else $error("mix pump disagrees with phase");

    a_units: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.ph_units <= 4'd14)
        else $error("pH units out of range");

endmodule

bind ph_dosing_controller phdc_checker u_phdc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
